// File: design/iff_pkg.sv
// iff_pkg: conversion codes, character constants and digit helpers for the
// integer field formatter and its checker
// no dependencies
`default_nettype none

package iff_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 63;

    // digit slots of the text shift register, top digit first
    localparam int unsigned DIGIT_SLOTS = 11;
    localparam int unsigned DEC_DIGITS  = 10;
    localparam int unsigned HEX_DIGITS  = 8;
    localparam int unsigned OCT_DIGITS  = 11;
    localparam int unsigned CONV_STEPS  = 32;

    typedef enum logic [1:0] {
        FUNC_CHAR = 2'd0,
        FUNC_DEC  = 2'd1,
        FUNC_HEX  = 2'd2,
        FUNC_OCT  = 2'd3
    } func_t;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    // 'A' - 10
    localparam logic [7:0] CHAR_ALPHA = 8'h37;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
        begin
            r = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            r = CHAR_ALPHA + {4'd0, d};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/integer_field_formatter.sv
// integer_field_formatter: one printf-style conversion per request, characters out one per cycle
// sequence: the request is registered, decimal first runs double dabble over all 32 input bits,
// then leading zero digits are dropped one per cycle, then left pad, sign, digits and right pad
// are shown; the block stays busy for the whole field, conversion and zero dropping included;
// the next request is taken in the cycle that shows the last character; receiver cannot stall
// reset: asynchronous, returns to idle with no character pending; depends on iff_pkg
`default_nettype none

module integer_field_formatter
    import iff_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] value,
    input  wire logic [5:0]  width,
    input  wire logic        left_adjust,
    input  wire logic        zero_pad,
    output logic [7:0]       out_char,
    output logic             last,
    output logic             strobe
);

    localparam int unsigned DIG_BITS = 4 * DIGIT_SLOTS;
    localparam int unsigned BCD_BITS = 4 * DEC_DIGITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_PADL,
        S_SIGN,
        S_DIGITS,
        S_PADR
    } state_t;

    state_t                state_reg, state_next;
    logic [DIG_BITS-1:0]   dig_reg, dig_next;
    logic [31:0]           bin_reg, bin_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic [3:0]            ndig_reg, ndig_next;
    logic [5:0]            w_reg, w_next;
    logic [7:0]            char_reg, char_next;
    logic                  is_char_reg, is_char_next;
    logic                  neg_reg, neg_next;
    logic                  left_reg, left_next;
    logic                  zpad_reg, zpad_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  last_reg, last_next;
    logic                  strobe_reg, strobe_next;

    logic [DIG_BITS-1:0]   oct_load;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic [4:0]            text_len;
    logic [5:0]            extra;
    logic [5:0]            w_sat;
    logic [7:0]            pad_char;
    logic [3:0]            top_digit;

    // octal: 33-bit view, top digit takes two bits, each digit in a 4-bit slot
    always_comb
    begin
        oct_load = '0;
        oct_load[DIG_BITS-1 -: 4] = {2'b00, value[31:30]};
        for (int i = 1; i < OCT_DIGITS; i++)
        begin
            oct_load[DIG_BITS-4-4*i +: 4] = {1'b0, value[30-3*i +: 3]};
        end
    end

    // double dabble: add 3 to every bcd digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (dig_reg[DIG_BITS-BCD_BITS+4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = dig_reg[DIG_BITS-BCD_BITS+4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = dig_reg[DIG_BITS-BCD_BITS+4*i +: 4];
            end
        end
    end

    assign w_sat     = (width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : width;
    assign top_digit = dig_reg[DIG_BITS-1 -: 4];
    assign text_len  = {1'b0, ndig_reg} + {4'd0, neg_reg};
    assign extra     = (w_reg > {1'b0, text_len}) ? (w_reg - {1'b0, text_len}) : 6'd0;
    assign pad_char  = zpad_reg ? CHAR_ZERO : CHAR_SPACE;

    always_comb
    begin
        state_next    = state_reg;
        dig_next      = dig_reg;
        bin_next      = bin_reg;
        cnt_next      = cnt_reg;
        ndig_next     = ndig_reg;
        w_next        = w_reg;
        char_next     = char_reg;
        is_char_next  = is_char_reg;
        neg_next      = neg_reg;
        left_next     = left_reg;
        zpad_next     = zpad_reg;
        out_char_next = out_char_reg;
        last_next     = 1'b0;
        strobe_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    w_next       = w_sat;
                    left_next    = left_adjust;
                    zpad_next    = zero_pad;
                    char_next    = value[7:0];
                    is_char_next = 1'b0;
                    neg_next     = 1'b0;
                    case (func_t'(func))
                        FUNC_CHAR:
                        begin
                            is_char_next = 1'b1;
                            ndig_next    = 4'd1;
                            state_next   = S_SKIP;
                        end
                        FUNC_DEC:
                        begin
                            neg_next   = value[31];
                            bin_next   = value[31] ? (32'd0 - value) : value;
                            dig_next   = '0;
                            cnt_next   = 6'(CONV_STEPS - 1);
                            ndig_next  = 4'(DEC_DIGITS);
                            state_next = S_CONV;
                        end
                        FUNC_HEX:
                        begin
                            dig_next   = {value, {(DIG_BITS-32){1'b0}}};
                            ndig_next  = 4'(HEX_DIGITS);
                            state_next = S_SKIP;
                        end
                        FUNC_OCT:
                        begin
                            dig_next   = oct_load;
                            ndig_next  = 4'(OCT_DIGITS);
                            state_next = S_SKIP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV:
            begin
                dig_next[DIG_BITS-1 -: BCD_BITS] = {bcd_adj[BCD_BITS-2:0], bin_reg[31]};
                bin_next = {bin_reg[30:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // drop leading zeros, keeping at least one digit
                if (!is_char_reg && top_digit == 4'd0 && ndig_reg != 4'd1)
                begin
                    dig_next  = {dig_reg[DIG_BITS-5:0], 4'd0};
                    ndig_next = ndig_reg - 4'd1;
                end
                else
                begin
                    cnt_next = extra;
                    if (!left_reg && extra != 6'd0)
                    begin
                        state_next = S_PADL;
                    end
                    else if (neg_reg)
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        state_next = S_DIGITS;
                    end
                end
            end
            S_PADL:
            begin
                out_char_next = pad_char;
                strobe_next   = 1'b1;
                cnt_next      = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = neg_reg ? S_SIGN : S_DIGITS;
                end
            end
            S_SIGN:
            begin
                out_char_next = CHAR_MINUS;
                strobe_next   = 1'b1;
                state_next    = S_DIGITS;
            end
            S_DIGITS:
            begin
                out_char_next = is_char_reg ? char_reg : digit_ascii(top_digit);
                strobe_next   = 1'b1;
                dig_next      = {dig_reg[DIG_BITS-5:0], 4'd0};
                ndig_next     = ndig_reg - 4'd1;
                if (ndig_reg == 4'd1)
                begin
                    // cnt still holds the pad count when left-justified
                    if (left_reg && cnt_reg != 6'd0)
                    begin
                        state_next = S_PADR;
                    end
                    else
                    begin
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_PADR:
            begin
                out_char_next = pad_char;
                strobe_next   = 1'b1;
                cnt_next      = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            dig_reg      <= '0;
            bin_reg      <= '0;
            cnt_reg      <= '0;
            ndig_reg     <= '0;
            w_reg        <= '0;
            char_reg     <= '0;
            is_char_reg  <= 1'b0;
            neg_reg      <= 1'b0;
            left_reg     <= 1'b0;
            zpad_reg     <= 1'b0;
            out_char_reg <= '0;
            last_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dig_reg      <= dig_next;
            bin_reg      <= bin_next;
            cnt_reg      <= cnt_next;
            ndig_reg     <= ndig_next;
            w_reg        <= w_next;
            char_reg     <= char_next;
            is_char_reg  <= is_char_next;
            neg_reg      <= neg_next;
            left_reg     <= left_next;
            zpad_reg     <= zpad_next;
            out_char_reg <= out_char_next;
            last_reg     <= last_next;
            strobe_reg   <= strobe_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign out_char = out_char_reg;
    assign last     = last_reg;
    assign strobe   = strobe_reg;

endmodule

`default_nettype wire

// File: design/iff_checker.sv
// iff_checker: port-level checks on request and character sequencing of the formatter
// bound to integer_field_formatter; no package needed
`default_nettype none

module iff_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic last,
    input wire logic strobe
);

    // an accepted request keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("request accepted but block not busy");

    assert property (@(posedge clk) disable iff (!rst_n) last |-> strobe)
        else $error("last mark without a character");

    // the final character is shown exactly as the block goes idle
    assert property (@(posedge clk) disable iff (!rst_n) strobe && last |-> !busy)
        else $error("busy after final character");

    assert property (@(posedge clk) disable iff (!rst_n) strobe && !busy |-> last)
        else $error("idle while field still running");

    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> strobe && last)
        else $error("busy dropped without final character");

endmodule

bind integer_field_formatter iff_checker u_iff_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .last   (last),
    .strobe (strobe)
);

`default_nettype wire
